### rtl/core/rdc_pkg.sv
// Shared widths and constants for the radix digit converter.
package rdc_pkg;

   localparam int VALUE_W        = 64;
   localparam int DIGIT_W        = 6;
   localparam int RADIX_REG_W    = 6;
   localparam int PTR_W          = 6;
   localparam int DEF_MAX_RADIX  = 36;
   localparam int MIN_RADIX      = 2;
   localparam int BITS_PER_CYCLE = 8;

   localparam logic [RADIX_REG_W-1:0] RADIX_RESET = RADIX_REG_W'(10);

endpackage

### rtl/core/radix_digit_converter_unit.sv
// Top level of the radix digit converter: sequencer, digit store and output stage.
//
// A transaction on the req_ channel carries a 64-bit value and a signed flag.
// A signed negative value is converted as its magnitude, with no sign digit.
// The value is split into digits of the radix held in the csr_ register by
// repeated division; each digit leaves as one transaction on the rsp_ channel,
// most significant first, with rsp_last_digit set on the final digit. Zero
// gives one digit 0.
// The divider retires 8 quotient bits per cycle; the digits are kept in a
// 64-entry store and read back in reverse, one digit after another.
// req_stall is high from acceptance until the last digit has been taken.
// While rsp_stall is high the current digit holds on the rsp_ ports.
// Reset returns the sequencer to idle and the radix to 10. Radix values below
// 2 act as 2 and values above MAX_RADIX act as MAX_RADIX. csr_ready is always high;
// the user must write the radix only while the block is idle; the block itself does not enforce it.
module radix_digit_converter_unit
   import rdc_pkg::*;
#(
   parameter int MAX_RADIX = DEF_MAX_RADIX
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [VALUE_W-1:0]     req_value,
   input  logic                   req_value_is_signed,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [DIGIT_W-1:0]     rsp_digit,
   output logic                   rsp_last_digit,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [RADIX_REG_W-1:0] csr_radix
);

   localparam int RADIX_W = $clog2(MAX_RADIX + 1);
   localparam int CMP_W   = RADIX_REG_W + 1;
   localparam int DEPTH   = 1 << PTR_W;

   typedef enum logic [1:0] {
      S_IDLE,
      S_DIV,
      S_READ,
      S_SHOW
   } state_type;

   state_type                state_ff;
   state_type                state_in;
   logic [PTR_W-1:0]         wr_ptr_ff;
   logic [PTR_W-1:0]         wr_ptr_in;
   logic [PTR_W-1:0]         rd_ptr_ff;
   logic [PTR_W-1:0]         rd_ptr_in;
   logic                     last_ff;
   logic                     last_in;
   logic [RADIX_REG_W-1:0]   radix_ff;
   logic [RADIX_W-1:0]       radix_eff;
   logic [VALUE_W-1:0]       magnitude;
   logic [VALUE_W-1:0]       div_dividend;
   logic                     div_start;
   logic                     div_done;
   logic [VALUE_W-1:0]       div_quotient;
   logic [RADIX_W-1:0]       div_remainder;
   logic                     req_accept;
   logic                     mem_wr;
   logic                     mem_rd;
   logic [DIGIT_W-1:0]       digit_mem [DEPTH];
   logic [DIGIT_W-1:0]       digit_rd_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         radix_ff <= RADIX_RESET;
      end else if (csr_valid && csr_ready) begin
         radix_ff <= csr_radix;
      end
   end

   always_comb begin
      if (radix_ff < RADIX_REG_W'(MIN_RADIX)) begin
         radix_eff = RADIX_W'(MIN_RADIX);
      end else if ({1'b0, radix_ff} > CMP_W'(MAX_RADIX)) begin
         radix_eff = RADIX_W'(MAX_RADIX);
      end else begin
         radix_eff = RADIX_W'(radix_ff);
      end
   end

   assign magnitude = (req_value_is_signed && req_value[VALUE_W-1]) ?
                      (~req_value + 1'b1) : req_value;

   assign req_stall  = (state_ff != S_IDLE);
   assign req_accept = req_valid && !req_stall;

   // A new division starts on acceptance, or on the quotient of the last one while that quotient is nonzero.
   assign div_start    = req_accept ||
                         ((state_ff == S_DIV) && div_done && (div_quotient != '0));
   assign div_dividend = (state_ff == S_IDLE) ? magnitude : div_quotient;

   rdc_divider #(
      .RADIX_W (RADIX_W)
   ) u_divider (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (div_dividend),
      .divisor   (radix_eff),
      .done      (div_done),
      .quotient  (div_quotient),
      .remainder (div_remainder)
   );

   assign mem_wr = (state_ff == S_DIV) && div_done;
   assign mem_rd = (state_ff == S_READ);

   // Digits are stored least significant first and read back from the top.
   always_ff @(posedge clock) begin
      if (mem_wr) begin
         digit_mem[wr_ptr_ff] <= DIGIT_W'(div_remainder);
      end
   end

   always_ff @(posedge clock) begin
      if (mem_rd) begin
         digit_rd_ff <= digit_mem[rd_ptr_ff];
      end
   end

   always_comb begin
      state_in  = state_ff;
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      last_in   = last_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               state_in  = S_DIV;
               wr_ptr_in = '0;
            end
         end
         S_DIV: begin
            if (div_done) begin
               if (div_quotient == '0) begin
                  state_in  = S_READ;
                  rd_ptr_in = wr_ptr_ff;
               end else begin
                  wr_ptr_in = wr_ptr_ff + 1'b1;
               end
            end
         end
         S_READ: begin
            state_in = S_SHOW;
            last_in  = (rd_ptr_ff == '0);
         end
         S_SHOW: begin
            if (!rsp_stall) begin
               if (last_ff) begin
                  state_in = S_IDLE;
               end else begin
                  state_in  = S_READ;
                  rd_ptr_in = rd_ptr_ff - 1'b1;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         last_ff   <= 1'b0;
      end else begin
         state_ff  <= state_in;
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         last_ff   <= last_in;
      end
   end

   assign rsp_valid      = (state_ff == S_SHOW);
   assign rsp_digit      = digit_rd_ff;
   assign rsp_last_digit = last_ff;

   assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == S_DIV))
      else $error("divider finished outside the divide phase");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (CMP_W'(rsp_digit) < CMP_W'(radix_eff)))
      else $error("digit out of range for the current radix");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_last_digit && !rsp_stall) |=> !req_stall && !rsp_valid)
      else $error("block did not return to idle after the final digit");

   assert property (@(posedge clock) disable iff (reset)
      req_accept |=> (state_ff == S_DIV) && (wr_ptr_ff == '0))
      else $error("accepted transaction did not start a conversion");

endmodule

### rtl/core/rdc_divider.sv
// Iterative restoring divider: 64-bit dividend by a small radix, several bits per cycle.
module rdc_divider
   import rdc_pkg::*;
#(
   parameter int RADIX_W = 6
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [VALUE_W-1:0]   dividend,
   input  logic [RADIX_W-1:0]   divisor,
   output logic                 done,
   output logic [VALUE_W-1:0]   quotient,
   output logic [RADIX_W-1:0]   remainder
);

   localparam int STEPS = VALUE_W / BITS_PER_CYCLE;
   localparam int CNT_W = (STEPS > 1) ? $clog2(STEPS) : 1;

   logic [VALUE_W-1:0] num_ff;
   logic [VALUE_W-1:0] num_in;
   logic [RADIX_W-1:0] rem_ff;
   logic [RADIX_W-1:0] rem_in;
   logic [RADIX_W-1:0] div_ff;
   logic [CNT_W-1:0]   cnt_ff;
   logic               run_ff;
   logic               done_ff;
   logic [RADIX_W:0]   trial;

   // The dividend shifts out at the top while quotient bits shift in at the bottom.
   always_comb begin
      rem_in = rem_ff;
      num_in = num_ff;
      trial  = '0;
      for (int i = 0; i < BITS_PER_CYCLE; i++) begin
         trial  = {rem_in, num_in[VALUE_W-1]};
         num_in = {num_in[VALUE_W-2:0], 1'b0};
         if (trial >= {1'b0, div_ff}) begin
            rem_in    = RADIX_W'(trial - {1'b0, div_ff});
            num_in[0] = 1'b1;
         end else begin
            rem_in = RADIX_W'(trial);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            run_ff <= 1'b1;
            cnt_ff <= '0;
         end else if (run_ff) begin
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(STEPS - 1)) begin
               run_ff  <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         num_ff <= dividend;
         rem_ff <= '0;
         div_ff <= divisor;
      end else if (run_ff) begin
         num_ff <= num_in;
         rem_ff <= rem_in;
      end
   end

   assign done      = done_ff;
   assign quotient  = num_ff;
   assign remainder = rem_ff;

endmodule
